@@ rtl/core/tcf_pkg.sv @@
// package for the tilt complementary filter: constants, types, arctangent table
// no dependencies
`default_nettype none
package tcf_pkg;
  localparam int CalibSamples = 256;
  localparam int CalibLog2 = 8;
  localparam int CordicSteps = 16;
  localparam int StepW = 5;
  localparam int AngW = 26;

  // rate divide: 131e6 = 64 * 2046875, reciprocal is floor(2^52 / 2046875)
  localparam logic [31:0] DivScaled = 32'd2046875;
  localparam logic [31:0] RecipMul = 32'd2200231879;

  localparam logic [0:0] KIND_CALIB = 1'b0;
  localparam logic [0:0] KIND_FILTER = 1'b1;

  localparam logic [0:0] REG_AXIS_ENABLE = 1'b0;
  localparam logic [0:0] REG_BLEND_WEIGHT = 1'b1;

  localparam logic signed [AngW-1:0] Deg90 = 26'sd5898240;
  localparam logic signed [AngW-1:0] AngMax = 26'sh1FFFFFF;
  localparam logic signed [AngW-1:0] AngMin = -26'sh2000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AXIS, ST_MUL1, ST_DIV, ST_PRE, ST_ITER, ST_BLEND1, ST_BLEND2,
    ST_STORE, ST_OUT1, ST_OUT2, ST_DONE
  } state_t;

  typedef struct packed {
    logic kind;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [23:0] elapsed_ticks;
  } item_t;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;
      5'd2: r = 26'sd919879;   5'd3: r = 26'sd466945;
      5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;
      5'd8: r = 26'sd14668;    5'd9: r = 26'sd7334;
      5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;     5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;     5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;       5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/tcf_divider.sv @@
// divide by 131e6 with truncation toward zero, by reciprocal multiplication
// dividend is a multiple of 2^18 below 2^58 in magnitude; uses tcf_pkg
`default_nettype none
module tcf_divider (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire signed [63:0] dividend,
  output logic              busy,
  output logic signed [63:0] quotient
);
  import tcf_pkg::*;

  logic [39:0] num;     // magnitude of dividend / 2^18
  logic        neg;
  logic [1:0]  phase;
  logic [71:0] est;
  logic [31:0] q0;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [51:0] rem;

  // one shared 32 x 32 multiplier
  always_comb begin
    case (phase)
      2'd0: begin
        mul_a = {12'd0, num[39:20]};
        mul_b = RecipMul;
      end
      2'd1: begin
        mul_a = {12'd0, num[19:0]};
        mul_b = RecipMul;
      end
      default: begin
        mul_a = q0;
        mul_b = DivScaled;
      end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // remainder of the estimate, below twice the scaled divisor
  assign rem = {num, 12'd0} - mul_p[51:0];

  // estimate from the reciprocal, then at most one correction
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= '0;
    end else if (start) begin
      busy <= 1'b1;
      phase <= '0;
      neg <= dividend[63];
      num <= dividend[63] ? 40'((-dividend) >>> 18) : 40'(dividend >>> 18);
    end else if (busy) begin
      phase <= phase + 2'd1;
      case (phase)
        2'd0: est <= 72'({mul_p, 20'd0});
        2'd1: est <= est + 72'(mul_p);
        2'd2: q0 <= est[71:40];
        default: begin
          if (rem >= 52'(DivScaled)) q0 <= q0 + 32'd1;
          busy <= 1'b0;
        end
      endcase
    end
  end

  assign quotient = neg ? -$signed({32'd0, q0}) : $signed({32'd0, q0});
endmodule
`default_nettype wire

@@ rtl/core/tilt_complementary_filter.sv @@
// tilt complementary filter top level: sequencer with multipliers, divider, cordic
// uses tcf_pkg and tcf_divider
// one item at a time: no new input is taken until the result has been accepted; each
// enabled axis runs a divide and the 16-step cordic
// reset: angles, offsets, sums and count cleared, registers to 0xfff and 58982
`default_nettype none
module tilt_complementary_filter (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [119:0] s_axis_tdata,  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, ticks
  input  wire         s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,  // angle_x_centi, angle_y_centi, angle_z_centi
  output logic        m_axis_tuser,  // offsets_ready
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import tcf_pkg::*;

  state_t state, state_next;
  logic [11:0] axis_enable;
  logic [15:0] blend_weight;
  logic signed [AngW-1:0] angles [3];
  logic signed [15:0] offs [3];
  logic signed [31:0] sums [3];
  logic [CalibLog2:0] calib_count;
  logic ready_flag;
  item_t it;
  logic [1:0] ax;      // 2 = z, 1 = y, 0 = x
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [33:0] sval;
  logic signed [25:0] cx, cy;
  logic signed [AngW-1:0] cz;
  logic [StepW-1:0] step;
  logic [1:0] oidx;
  logic signed [15:0] cen [3];
  logic div_start, div_busy;
  logic signed [63:0] div_q;

  tcf_divider u_div (.clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .busy(div_busy), .quotient(div_q));

  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE);

  // per-axis operand selection
  logic signed [15:0] g_sel, ya, xa;
  logic en_sel;
  always_comb begin
    case (ax)
      2'd2: begin g_sel = it.gyro_z; ya = it.accel_x; xa = it.accel_y;
        en_sel = |axis_enable[3:0]; end
      2'd1: begin g_sel = it.gyro_y; ya = it.accel_x; xa = it.accel_z;
        en_sel = |axis_enable[7:4]; end
      default: begin g_sel = it.gyro_x; ya = it.accel_z; xa = it.accel_y;
        en_sel = |axis_enable[11:8]; end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_AXIS;
      ST_AXIS: begin
        if (it.kind == KIND_CALIB) state_next = ST_OUT1;
        else if (en_sel) state_next = ST_MUL1;
        else if (ax == 2'd0) state_next = ST_OUT1;
      end
      ST_MUL1: state_next = ST_DIV;
      ST_DIV: begin
        div_start = (step == '0);
        if (step != '0 && !div_busy) state_next = ST_PRE;
      end
      ST_PRE: state_next = ST_ITER;
      ST_ITER: if (step == StepW'(CordicSteps - 1)) state_next = ST_BLEND1;
      ST_BLEND1: state_next = ST_BLEND2;
      ST_BLEND2: state_next = ST_STORE;
      ST_STORE: state_next = (ax == 2'd0) ? ST_OUT1 : ST_AXIS;
      ST_OUT1: if (oidx == 2'd2) state_next = ST_OUT2;
      ST_OUT2: state_next = ST_DONE;
      ST_DONE: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign m_axis_tvalid = (state == ST_DONE);
  assign m_axis_tdata = {cen[2], cen[1], cen[0]};
  assign m_axis_tuser = ready_flag;

  logic signed [AngW-1:0] xs, ys;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  logic signed [63:0] centi_prod;
  assign centi_prod = 64'(angles[oidx]) * 64'sd100;
  logic signed [63:0] centi_q;
  assign centi_q = (centi_prod < 0) ? -((-centi_prod) >>> 16) : centi_prod >>> 16;

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_enable <= 12'hFFF;
      blend_weight <= 16'd58982;
      for (int i = 0; i < 3; i++) begin
        angles[i] <= '0; offs[i] <= '0; sums[i] <= '0;
      end
      calib_count <= '0;
      ready_flag <= 1'b0;
      step <= '0;
      ax <= 2'd2;
      oidx <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_AXIS_ENABLE) axis_enable <= cfg_data[11:0];
        else blend_weight <= cfg_data;
      end
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          it <= {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
            s_axis_tdata[47:32], s_axis_tdata[63:48], s_axis_tdata[79:64],
            s_axis_tdata[95:80], s_axis_tdata[119:96]};
          ax <= 2'd2;
          oidx <= '0;
        end
        ST_AXIS: begin
          step <= '0;
          if (it.kind == KIND_CALIB) begin
            if (calib_count == (CalibLog2+1)'(CalibSamples - 1)) begin
              offs[0] <= 16'((33'(sums[0]) + 33'(it.gyro_x)) / CalibSamples);
              offs[1] <= 16'((33'(sums[1]) + 33'(it.gyro_y)) / CalibSamples);
              offs[2] <= 16'((33'(sums[2]) + 33'(it.gyro_z)) / CalibSamples);
              for (int i = 0; i < 3; i++) sums[i] <= '0;
              calib_count <= '0;
              ready_flag <= 1'b1;
            end else begin
              sums[0] <= sums[0] + 32'(it.gyro_x);
              sums[1] <= sums[1] + 32'(it.gyro_y);
              sums[2] <= sums[2] + 32'(it.gyro_z);
              calib_count <= calib_count + 1'b1;
            end
          end else if (!en_sel && ax != 2'd0) ax <= ax - 2'd1;
          // d * ticks, 17 x 24 bits
          prod <= 64'(17'(g_sel) - 17'(offs[ax])) * $signed({1'b0, it.elapsed_ticks});
        end
        ST_MUL1: prod <= prod <<< 18;
        ST_DIV: if (step == '0) step <= 5'd1;
          else if (!div_busy) begin
            sval <= 34'(64'(angles[ax]) + div_q);
            step <= '0;
          end
        ST_PRE: begin
          cx <= 26'(xa) <<< 8; cy <= 26'(ya) <<< 8; cz <= '0;
          if (xa < 0) begin
            if (ya >= 0) begin cx <= 26'(ya) <<< 8; cy <= -(26'(xa) <<< 8); cz <= Deg90; end
            else begin cx <= -(26'(ya) <<< 8); cy <= 26'(xa) <<< 8; cz <= -Deg90; end
          end
        end
        ST_ITER: begin
          if (cy >= 0) begin cx <= cx + ys; cy <= cy - xs; cz <= cz + atan_lut(step); end
          else begin cx <= cx - ys; cy <= cy + xs; cz <= cz - atan_lut(step); end
          step <= step + 1'b1;
        end
        ST_BLEND1: begin
          if (it.accel_x == 0 && it.accel_y == 0 && ax == 2'd2) cz <= '0;
          if (it.accel_x == 0 && it.accel_z == 0 && ax == 2'd1) cz <= '0;
          if (it.accel_z == 0 && it.accel_y == 0 && ax == 2'd0) cz <= '0;
          acc <= 64'(sval) * $signed({1'b0, 16'(blend_weight)});
        end
        ST_BLEND2: acc <= acc + 64'(cz) * (64'sd65536 - 64'({1'b0, blend_weight}));
        ST_STORE: begin
          logic signed [63:0] v;
          v = (acc < 0) ? -((-acc) >>> 16) : acc >>> 16;
          if (v > 64'(AngMax)) angles[ax] <= AngMax;
          else if (v < 64'(AngMin)) angles[ax] <= AngMin;
          else angles[ax] <= AngW'(v);
          if (ax != 2'd0) ax <= ax - 2'd1;
        end
        ST_OUT1: begin
          if (centi_q > 64'sd32767) cen[oidx] <= 16'sh7FFF;
          else if (centi_q < -64'sd32768) cen[oidx] <= -16'sh8000;
          else cen[oidx] <= 16'(centi_q);
          oidx <= oidx + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // result held while the sink stalls
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // no input taken while the result is offered
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted during output");
  // calibration count stays in range
  assert property (@(posedge clk) disable iff (rst)
    calib_count < (CalibLog2+1)'(CalibSamples))
    else $error("calibration count overflow");
endmodule
`default_nettype wire
